>>> src/gfb_pkg.sv
package gfb_pkg;

  localparam int BinW     = 8;
  localparam int NumBins  = 2 ** BinW;
  localparam int CfgW     = 9;
  localparam int KindW    = 2;
  localparam int CoefW    = 19;
  localparam int SampleW  = 16;
  localparam int StateW   = 48;
  localparam int FracW    = 16;
  localparam int MagW     = 63;
  localparam int PairW    = 2 * StateW;

  localparam logic [CfgW-1:0] ActiveReset = CfgW'(151);

  // shared multiplier: 24-bit digits, signed 25x25 product
  localparam int DigW     = 24;
  localparam int MulW     = DigW + 1;
  localparam int ProdW    = 2 * MulW;
  localparam int AccW     = 115;
  localparam int ShiftW   = 7;
  localparam int MagShift = 3 * FracW;

  // g*s1 product bits and the widened update sum
  localparam int GsTop    = StateW + CoefW - 1;
  localparam int UpdW     = StateW + 5;

  // magnitude micro program
  localparam int MagSteps = 16;
  localparam int MagStepW = $clog2(MagSteps);
  localparam int PCapture = 5;
  localparam int MagLast  = MagSteps + 1;
  localparam int CntW     = $clog2(MagLast + 1);

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_WAIT,
    ST_WRITE,
    ST_MAG
  } seq_state_e;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef enum logic [3:0] {
    SEL_S1_LO,
    SEL_S1_HI,
    SEL_S2_LO,
    SEL_S2_HI,
    SEL_G,
    SEL_P0,
    SEL_P1,
    SEL_P2,
    SEL_P3
  } opnd_sel_e;

  typedef struct packed {
    opnd_sel_e             sel_a;
    opnd_sel_e             sel_b;
    mac_op_e               op;
    logic [ShiftW-1:0]     shift;
  } mac_step_t;

  typedef struct packed {
    logic                  issue;
    mac_op_e               op;
    logic [ShiftW-1:0]     shift;
  } mac_ctl_t;

  typedef struct packed {
    logic                  rd_en;
    logic [BinW-1:0]       rd_addr;
    logic                  wr_en;
    logic                  coef_we;
    logic [BinW-1:0]       wr_addr;
    logic                  clr_all;
  } store_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic [BinW-1:0]       bin;
  } done_t;

  // P = s1*s2, then (s1^2 + s2^2) << 16, then subtract g*P
  function automatic mac_step_t mag_step(input logic [MagStepW-1:0] idx);
    mac_step_t s;
    s = '{SEL_S1_LO, SEL_S2_LO, MAC_LOAD, ShiftW'(0)};
    case (idx)
      4'd0:  s = '{SEL_S1_LO, SEL_S2_LO, MAC_LOAD, ShiftW'(0)};
      4'd1:  s = '{SEL_S1_LO, SEL_S2_HI, MAC_ADD,  ShiftW'(DigW)};
      4'd2:  s = '{SEL_S1_HI, SEL_S2_LO, MAC_ADD,  ShiftW'(DigW)};
      4'd3:  s = '{SEL_S1_HI, SEL_S2_HI, MAC_ADD,  ShiftW'(2 * DigW)};
      4'd4:  s = '{SEL_S1_LO, SEL_S1_LO, MAC_LOAD, ShiftW'(FracW)};
      4'd5:  s = '{SEL_S1_LO, SEL_S1_HI, MAC_ADD,  ShiftW'(DigW + FracW)};
      4'd6:  s = '{SEL_S1_HI, SEL_S1_LO, MAC_ADD,  ShiftW'(DigW + FracW)};
      4'd7:  s = '{SEL_S1_HI, SEL_S1_HI, MAC_ADD,  ShiftW'(2 * DigW + FracW)};
      4'd8:  s = '{SEL_S2_LO, SEL_S2_LO, MAC_ADD,  ShiftW'(FracW)};
      4'd9:  s = '{SEL_S2_LO, SEL_S2_HI, MAC_ADD,  ShiftW'(DigW + FracW)};
      4'd10: s = '{SEL_S2_HI, SEL_S2_LO, MAC_ADD,  ShiftW'(DigW + FracW)};
      4'd11: s = '{SEL_S2_HI, SEL_S2_HI, MAC_ADD,  ShiftW'(2 * DigW + FracW)};
      4'd12: s = '{SEL_P0,    SEL_G,     MAC_SUB,  ShiftW'(0)};
      4'd13: s = '{SEL_P1,    SEL_G,     MAC_SUB,  ShiftW'(DigW)};
      4'd14: s = '{SEL_P2,    SEL_G,     MAC_SUB,  ShiftW'(2 * DigW)};
      4'd15: s = '{SEL_P3,    SEL_G,     MAC_SUB,  ShiftW'(3 * DigW)};
      default: s = '{SEL_S1_LO, SEL_S2_LO, MAC_LOAD, ShiftW'(0)};
    endcase
    return s;
  endfunction

endpackage

>>> src/gfb_mac.sv
module gfb_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gfb_pkg::mac_ctl_t                      ctl_i,
  input  logic signed [gfb_pkg::MulW-1:0]        a_i,
  input  logic signed [gfb_pkg::MulW-1:0]        b_i,
  output logic signed [gfb_pkg::AccW-1:0]        acc_o
);

  logic signed [gfb_pkg::ProdW-1:0] prod_d, prod_q;
  gfb_pkg::mac_ctl_t                ctl_q;
  logic signed [gfb_pkg::AccW-1:0]  term;
  logic signed [gfb_pkg::AccW-1:0]  acc_d, acc_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{issue: 1'b0, op: gfb_pkg::MAC_LOAD, shift: '0};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      prod_q <= prod_d;
    end
    if (ctl_q.issue) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    term  = gfb_pkg::AccW'(prod_q) <<< ctl_q.shift;
    acc_d = acc_q;
    case (ctl_q.op)
      gfb_pkg::MAC_LOAD: acc_d = term;
      gfb_pkg::MAC_ADD:  acc_d = acc_q + term;
      gfb_pkg::MAC_SUB:  acc_d = acc_q - term;
      default:           acc_d = acc_q;
    endcase
  end

  assign acc_o = acc_q;

endmodule

>>> src/gfb_store.sv
module gfb_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gfb_pkg::store_ctl_t                    ctl_i,
  input  logic signed [gfb_pkg::CoefW-1:0]       coef_wdata_i,
  input  logic [gfb_pkg::PairW-1:0]              pair_wdata_i,
  output logic signed [gfb_pkg::CoefW-1:0]       coef_o,
  output logic signed [gfb_pkg::StateW-1:0]      s1_o,
  output logic signed [gfb_pkg::StateW-1:0]      s2_o
);

  logic signed [gfb_pkg::CoefW-1:0] coef_mem [gfb_pkg::NumBins];
  logic [gfb_pkg::PairW-1:0]        pair_mem [gfb_pkg::NumBins];

  logic signed [gfb_pkg::CoefW-1:0] coef_rd_q;
  logic [gfb_pkg::PairW-1:0]        pair_rd_q;
  logic [gfb_pkg::NumBins-1:0]      valid_d, valid_q;
  logic                             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.coef_we) begin
      coef_mem[ctl_i.wr_addr] <= coef_wdata_i;
    end
    if (ctl_i.rd_en) begin
      coef_rd_q <= coef_mem[ctl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      pair_mem[ctl_i.wr_addr] <= pair_wdata_i;
    end
    if (ctl_i.rd_en) begin
      pair_rd_q <= pair_mem[ctl_i.rd_addr];
    end
  end

  // bin state reads as zero until written since the last window start
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.clr_all) begin
      valid_d = '0;
    end else if (ctl_i.wr_en) begin
      valid_d[ctl_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[ctl_i.rd_addr] & ~ctl_i.clr_all;
      end
    end
  end

  assign coef_o = coef_rd_q;
  assign s1_o   = rd_valid_q ? signed'(pair_rd_q[gfb_pkg::PairW-1:gfb_pkg::StateW]) : '0;
  assign s2_o   = rd_valid_q ? signed'(pair_rd_q[gfb_pkg::StateW-1:0]) : '0;

endmodule

>>> src/gfb_seq.sv
module gfb_seq (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [gfb_pkg::KindW-1:0]              kind_i,
  input  logic [gfb_pkg::BinW-1:0]               bin_index_i,
  input  logic signed [gfb_pkg::SampleW-1:0]     sample_i,
  input  logic                                   start_window_i,
  input  logic [gfb_pkg::CfgW-1:0]               active_i,
  input  logic signed [gfb_pkg::CoefW-1:0]       coef_i,
  input  logic signed [gfb_pkg::StateW-1:0]      s1_i,
  input  logic signed [gfb_pkg::StateW-1:0]      s2_i,
  input  logic signed [gfb_pkg::AccW-1:0]        acc_i,
  output logic                                   busy_o,
  output gfb_pkg::store_ctl_t                    store_ctl_o,
  output logic [gfb_pkg::PairW-1:0]              pair_wdata_o,
  output gfb_pkg::mac_ctl_t                      mac_ctl_o,
  output logic signed [gfb_pkg::MulW-1:0]        a_o,
  output logic signed [gfb_pkg::MulW-1:0]        b_o,
  output gfb_pkg::done_t                         done_o
);

  gfb_pkg::seq_state_e               state_d, state_q;
  logic [gfb_pkg::CntW-1:0]          cnt_d, cnt_q;
  logic [gfb_pkg::BinW-1:0]          bin_d, bin_q;
  logic [gfb_pkg::BinW-1:0]          last_d, last_q;
  logic signed [gfb_pkg::SampleW-1:0] x_d, x_q;
  logic [gfb_pkg::PairW-1:0]         p_d, p_q;

  gfb_pkg::mac_step_t                step;
  gfb_pkg::opnd_sel_e                sel_a, sel_b;
  logic signed [gfb_pkg::UpdW-1:0]   upd;
  logic signed [gfb_pkg::StateW-1:0] s0;
  logic                              upd_fits;

  function automatic logic signed [gfb_pkg::MulW-1:0] pick(
    input gfb_pkg::opnd_sel_e              sel,
    input logic signed [gfb_pkg::StateW-1:0] s1,
    input logic signed [gfb_pkg::StateW-1:0] s2,
    input logic signed [gfb_pkg::CoefW-1:0]  g,
    input logic [gfb_pkg::PairW-1:0]         p
  );
    logic signed [gfb_pkg::MulW-1:0] r;
    case (sel)
      gfb_pkg::SEL_S1_LO: r = signed'({1'b0, s1[gfb_pkg::DigW-1:0]});
      gfb_pkg::SEL_S1_HI: r = gfb_pkg::MulW'(signed'(s1[gfb_pkg::StateW-1:gfb_pkg::DigW]));
      gfb_pkg::SEL_S2_LO: r = signed'({1'b0, s2[gfb_pkg::DigW-1:0]});
      gfb_pkg::SEL_S2_HI: r = gfb_pkg::MulW'(signed'(s2[gfb_pkg::StateW-1:gfb_pkg::DigW]));
      gfb_pkg::SEL_G:     r = gfb_pkg::MulW'(g);
      gfb_pkg::SEL_P0:    r = signed'({1'b0, p[gfb_pkg::DigW-1:0]});
      gfb_pkg::SEL_P1:    r = signed'({1'b0, p[2*gfb_pkg::DigW-1:gfb_pkg::DigW]});
      gfb_pkg::SEL_P2:    r = signed'({1'b0, p[3*gfb_pkg::DigW-1:2*gfb_pkg::DigW]});
      gfb_pkg::SEL_P3:    r = gfb_pkg::MulW'(signed'(p[gfb_pkg::PairW-1:3*gfb_pkg::DigW]));
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign step = gfb_pkg::mag_step(cnt_q[gfb_pkg::MagStepW-1:0]);

  // s0 = floor(g*s1 / 2^16) - s2 + x*2^16, saturated to the state width
  assign upd = gfb_pkg::UpdW'(signed'(acc_i[gfb_pkg::GsTop:gfb_pkg::FracW]))
             - gfb_pkg::UpdW'(s2_i)
             + (gfb_pkg::UpdW'(x_q) <<< gfb_pkg::FracW);
  assign upd_fits = (upd[gfb_pkg::UpdW-1:gfb_pkg::StateW-1] == '0) ||
                    (upd[gfb_pkg::UpdW-1:gfb_pkg::StateW-1] == '1);

  always_comb begin
    if (upd_fits) begin
      s0 = upd[gfb_pkg::StateW-1:0];
    end else if (upd[gfb_pkg::UpdW-1]) begin
      s0 = signed'({1'b1, {(gfb_pkg::StateW-1){1'b0}}});
    end else begin
      s0 = signed'({1'b0, {(gfb_pkg::StateW-1){1'b1}}});
    end
  end

  assign pair_wdata_o = {s0, s1_i};
  assign a_o          = pick(sel_a, s1_i, s2_i, coef_i, p_q);
  assign b_o          = pick(sel_b, s1_i, s2_i, coef_i, p_q);
  assign busy_o       = (state_q != gfb_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bin_d       = bin_q;
    last_d      = last_q;
    x_d         = x_q;
    p_d         = p_q;
    store_ctl_o = '0;
    mac_ctl_o   = '{issue: 1'b0, op: gfb_pkg::MAC_LOAD, shift: '0};
    sel_a       = gfb_pkg::SEL_G;
    sel_b       = gfb_pkg::SEL_S1_LO;
    done_o      = '{valid: 1'b0, bin: bin_q};

    case (state_q)
      gfb_pkg::ST_IDLE: begin
        if (start_i) begin
          case (gfb_pkg::kind_e'(kind_i))
            gfb_pkg::KIND_LOAD: begin
              store_ctl_o.coef_we = 1'b1;
              store_ctl_o.wr_addr = bin_index_i;
            end
            gfb_pkg::KIND_SAMPLE: begin
              store_ctl_o.clr_all = start_window_i;
              x_d = sample_i;
              if (active_i != '0) begin
                store_ctl_o.rd_en   = 1'b1;
                store_ctl_o.rd_addr = '0;
                bin_d               = '0;
                if (active_i >= gfb_pkg::CfgW'(gfb_pkg::NumBins)) begin
                  last_d = gfb_pkg::BinW'(gfb_pkg::NumBins - 1);
                end else begin
                  last_d = active_i[gfb_pkg::BinW-1:0] - gfb_pkg::BinW'(1);
                end
                state_d = gfb_pkg::ST_LO;
              end
            end
            gfb_pkg::KIND_READ: begin
              store_ctl_o.rd_en   = 1'b1;
              store_ctl_o.rd_addr = bin_index_i;
              bin_d               = bin_index_i;
              cnt_d               = '0;
              state_d             = gfb_pkg::ST_MAG;
            end
            default: ;
          endcase
        end
      end
      gfb_pkg::ST_LO: begin
        mac_ctl_o = '{issue: 1'b1, op: gfb_pkg::MAC_LOAD, shift: gfb_pkg::ShiftW'(0)};
        sel_a     = gfb_pkg::SEL_G;
        sel_b     = gfb_pkg::SEL_S1_LO;
        state_d   = gfb_pkg::ST_HI;
      end
      gfb_pkg::ST_HI: begin
        mac_ctl_o = '{issue: 1'b1, op: gfb_pkg::MAC_ADD,
                      shift: gfb_pkg::ShiftW'(gfb_pkg::DigW)};
        sel_a     = gfb_pkg::SEL_G;
        sel_b     = gfb_pkg::SEL_S1_HI;
        state_d   = gfb_pkg::ST_WAIT;
      end
      gfb_pkg::ST_WAIT: begin
        state_d = gfb_pkg::ST_WRITE;
      end
      gfb_pkg::ST_WRITE: begin
        store_ctl_o.wr_en   = 1'b1;
        store_ctl_o.wr_addr = bin_q;
        if (bin_q == last_q) begin
          state_d = gfb_pkg::ST_IDLE;
        end else begin
          store_ctl_o.rd_en   = 1'b1;
          store_ctl_o.rd_addr = bin_q + gfb_pkg::BinW'(1);
          bin_d               = bin_q + gfb_pkg::BinW'(1);
          state_d             = gfb_pkg::ST_LO;
        end
      end
      gfb_pkg::ST_MAG: begin
        if (cnt_q < gfb_pkg::CntW'(gfb_pkg::MagSteps)) begin
          mac_ctl_o = '{issue: 1'b1, op: step.op, shift: step.shift};
          sel_a     = step.sel_a;
          sel_b     = step.sel_b;
        end
        if (cnt_q == gfb_pkg::CntW'(gfb_pkg::PCapture)) begin
          p_d = acc_i[gfb_pkg::PairW-1:0];
        end
        cnt_d = cnt_q + gfb_pkg::CntW'(1);
        if (cnt_q == gfb_pkg::CntW'(gfb_pkg::MagLast)) begin
          done_o.valid = 1'b1;
          state_d      = gfb_pkg::ST_IDLE;
        end
      end
      default: state_d = gfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfb_pkg::ST_IDLE;
      cnt_q   <= '0;
      bin_q   <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bin_q   <= bin_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    p_q <= p_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctl_o.wr_en |-> !store_ctl_o.clr_all)
    else $error("state write during window clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctl_o.wr_en |-> (store_ctl_o.wr_addr <= last_q))
    else $error("state write beyond active bins");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gfb_pkg::ST_LO) |-> $past(store_ctl_o.rd_en))
    else $error("bin update without a preceding read");

endmodule

>>> src/goertzel_filter_bank_core.sv
// Coefficient load: written at the transfer edge, busy stays low.
// Sample: busy for 4*N cycles, N = min(active_bins, 256); one shared 25x25
//   multiplier takes two digit products per bin, plus read and write-back.
// Read: busy for 18 cycles, result strobe 18 cycles after the transfer;
//   16 multiplier passes and a two-stage accumulate. One item at a time.
// Reset (async, low): active_bins = 151, all bin state reads as zero,
//   coefficients undefined until loaded. The receiver cannot stall.
module goertzel_filter_bank_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [gfb_pkg::KindW-1:0]              kind_i,
  input  logic [gfb_pkg::BinW-1:0]               bin_index_i,
  input  logic signed [gfb_pkg::CoefW-1:0]       coefficient_i,
  input  logic signed [gfb_pkg::SampleW-1:0]     sample_i,
  input  logic                                   start_window_i,
  input  logic                                   cfg_we_i,
  input  logic [gfb_pkg::CfgW-1:0]               cfg_wdata_i,
  output logic                                   valid_o,
  output logic [gfb_pkg::BinW-1:0]               read_bin_o,
  output logic [gfb_pkg::MagW-1:0]               magnitude_o
);

  logic [gfb_pkg::CfgW-1:0]           active_q;
  gfb_pkg::store_ctl_t                store_ctl;
  gfb_pkg::mac_ctl_t                  mac_ctl;
  gfb_pkg::done_t                     done;
  logic [gfb_pkg::PairW-1:0]          pair_wdata;
  logic signed [gfb_pkg::CoefW-1:0]   coef;
  logic signed [gfb_pkg::StateW-1:0]  s1, s2;
  logic signed [gfb_pkg::MulW-1:0]    mul_a, mul_b;
  logic signed [gfb_pkg::AccW-1:0]    acc;
  logic [gfb_pkg::AccW-2-gfb_pkg::MagShift:0] mag_int;
  logic [gfb_pkg::MagW-1:0]           mag_d;
  logic                               valid_q;
  logic [gfb_pkg::BinW-1:0]           read_bin_q;
  logic [gfb_pkg::MagW-1:0]           mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= gfb_pkg::ActiveReset;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  gfb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .kind_i         (kind_i),
    .bin_index_i    (bin_index_i),
    .sample_i       (sample_i),
    .start_window_i (start_window_i),
    .active_i       (active_q),
    .coef_i         (coef),
    .s1_i           (s1),
    .s2_i           (s2),
    .acc_i          (acc),
    .busy_o         (busy),
    .store_ctl_o    (store_ctl),
    .pair_wdata_o   (pair_wdata),
    .mac_ctl_o      (mac_ctl),
    .a_o            (mul_a),
    .b_o            (mul_b),
    .done_o         (done)
  );

  gfb_store u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (store_ctl),
    .coef_wdata_i   (coefficient_i),
    .pair_wdata_i   (pair_wdata),
    .coef_o         (coef),
    .s1_o           (s1),
    .s2_o           (s2)
  );

  gfb_mac u_mac (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (mac_ctl),
    .a_i            (mul_a),
    .b_i            (mul_b),
    .acc_o          (acc)
  );

  // floor to integer, clamp at zero, saturate
  assign mag_int = acc[gfb_pkg::AccW-2:gfb_pkg::MagShift];

  always_comb begin
    if (acc[gfb_pkg::AccW-1]) begin
      mag_d = '0;
    end else if (mag_int[gfb_pkg::AccW-2-gfb_pkg::MagShift:gfb_pkg::MagW] != '0) begin
      mag_d = '1;
    end else begin
      mag_d = mag_int[gfb_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      read_bin_q <= done.bin;
      mag_q      <= mag_d;
    end
  end

  assign valid_o     = valid_q;
  assign read_bin_o  = read_bin_q;
  assign magnitude_o = mag_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobes on consecutive cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result transfer while still busy");

endmodule
